/* hdl/bsmmg_pkg.sv */
// Shared types and constants for the bounded sorted set with span queries.
package bsmmg_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W       = 32;
	localparam int CAP_W        = 7;
	localparam int CAP_RESET    = 64;

	// Command codes carried in an input item
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_FEW  = 2'd2
	} status_t;

	typedef struct packed {
		logic                     cmd;
		logic signed [DATA_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		status_t             status;
		logic [DATA_W-1:0]   shortest_gap;
		logic [DATA_W-1:0]   longest_gap;
		logic [CAP_W-1:0]    held_count;
	} out_item_t;

endpackage

/* hdl/bsmmg_sub.sv */
// Shared 33-bit subtractor used for every value compare and gap in the sequencer.
module bsmmg_sub (
	input  logic [bsmmg_pkg::DATA_W:0] a,
	input  logic [bsmmg_pkg::DATA_W:0] b,
	output logic [bsmmg_pkg::DATA_W:0] diff
);

	// One wide subtract; the sign of the result serves as the compare flag
	assign diff = a - b;

endmodule

/* hdl/bsmmg_mem.sv */
// Value store: one write port, one registered read port.
module bsmmg_mem #(
	parameter int DEPTH = bsmmg_pkg::CAPACITY_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [bsmmg_pkg::DATA_W-1:0]  wr_data,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [bsmmg_pkg::DATA_W-1:0]  rd_data
);

	logic [bsmmg_pkg::DATA_W-1:0] mem_q [DEPTH];

	// Write the addressed entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hdl/bounded_set_min_max_gap.sv */
// Top level: bounded sorted set of signed numbers with span queries.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | into      | in_valid/in_stall  | in_item  (cmd, value)
//  out     | out of    | out_valid/out_stall| out_item (status, gaps, count)
//  cfg     | into      | cfg_we             | cfg_data (capacity_limit)
//
// An add reads the entry below the insertion point, compares it with the new value and
// moves it up until the value lands; a query reads each held number, keeps the smallest
// gap and takes the span. A refused item goes straight to the result register. No new
// item is taken until the last result registers. The pace is set by the single read
// port of the store and the shared subtractor that all value compares and gaps use.
// Reset empties the set at once and sets the limit to 64; no clearing pass.
// A stalled result holds in the output register while the next item is taken.
module bounded_set_min_max_gap #(
	parameter int CAPACITY = bsmmg_pkg::CAPACITY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  bsmmg_pkg::in_item_t             in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output bsmmg_pkg::out_item_t            out_item,
	input  logic                            cfg_we,
	input  logic [bsmmg_pkg::CAP_W-1:0]     cfg_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > bsmmg_pkg::CAP_W) ? CW : bsmmg_pkg::CAP_W;
	localparam int DW = bsmmg_pkg::DATA_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_PUT,
		S_Q_RD,
		S_Q_CMP,
		S_Q_MIN,
		S_Q_LONG,
		S_FIN
	} state_t;

	state_t                       state_q;
	logic [CW-1:0]                count_q;
	logic [bsmmg_pkg::CAP_W-1:0]  cap_q;
	logic [DW-1:0]                val_q;
	logic [CW-1:0]                pos_q;
	logic [CW-1:0]                idx_q;
	logic [DW-1:0]                prev_q;
	logic [DW-1:0]                first_q;
	logic [DW-1:0]                gap_q;
	logic [DW-1:0]                short_q;
	logic [DW-1:0]                long_q;
	bsmmg_pkg::status_t           res_status_q;
	logic                         out_valid_q;
	bsmmg_pkg::out_item_t         out_item_q;

	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [DW-1:0]                wr_data;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic [DW-1:0]                rd_data;
	logic [DW:0]                  sub_a;
	logic [DW:0]                  sub_b;
	logic [DW:0]                  sub_diff;
	logic [LW-1:0]                eff_cap;
	logic                         accept;
	logic                         out_free;
	logic                         store_gt;
	logic                         gap_less;
	logic [CW-1:0]                pos_dec;
	logic [CW-1:0]                idx_inc;

	// Effective capacity is the smaller of the limit and the store depth
	assign eff_cap = (LW'(cap_q) < LW'(CAPACITY)) ? LW'(cap_q) : LW'(CAPACITY);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign pos_dec  = pos_q - 1'b1;
	assign idx_inc  = idx_q + 1'b1;

	// Compare flags from the shared subtractor
	assign store_gt = !sub_diff[DW] && (sub_diff != '0);
	assign gap_less = sub_diff[DW];

	// Route operands into the shared subtractor
	always_comb begin
		sub_a = '0;
		sub_b = '0;
		unique case (state_q)
			S_INS_CMP: begin
				sub_a = {rd_data[DW-1], rd_data};
				sub_b = {val_q[DW-1], val_q};
			end
			S_Q_CMP: begin
				sub_a = {1'b0, rd_data};
				sub_b = {1'b0, prev_q};
			end
			S_Q_MIN: begin
				sub_a = {1'b0, gap_q};
				sub_b = {1'b0, short_q};
			end
			S_Q_LONG: begin
				sub_a = {1'b0, prev_q};
				sub_b = {1'b0, first_q};
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	// Drive the store ports
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = pos_q[AW-1:0];
		wr_data = val_q;
		unique case (state_q)
			S_INS_RD: begin
				rd_en   = 1'b1;
				rd_addr = pos_dec[AW-1:0];
			end
			S_INS_CMP: begin
				wr_en   = 1'b1;
				wr_data = store_gt ? rd_data : val_q;
			end
			S_INS_PUT: begin
				wr_en = 1'b1;
			end
			S_Q_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_q[AW-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	bsmmg_sub u_sub (
		.a    (sub_a),
		.b    (sub_b),
		.diff (sub_diff)
	);

	bsmmg_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Hold the capacity limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bsmmg_pkg::CAP_W'(bsmmg_pkg::CAP_RESET);
		end else if (cfg_we) begin
			cap_q <= cfg_data;
		end
	end

	// Sequencer: state, count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			res_status_q <= bsmmg_pkg::ST_OK;
			pos_q        <= '0;
			idx_q        <= '0;
		end else begin
			// Raise valid when a result is loaded, drop it once taken
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q   <= in_item.value;
						short_q <= '0;
						long_q  <= '0;
						pos_q   <= count_q;
						idx_q   <= '0;
						if (in_item.cmd == bsmmg_pkg::CMD_ADD) begin
							if (LW'(count_q) >= eff_cap) begin
								res_status_q <= bsmmg_pkg::ST_FULL;
								state_q      <= S_FIN;
							end else begin
								res_status_q <= bsmmg_pkg::ST_OK;
								state_q      <= (count_q == '0) ? S_INS_PUT : S_INS_RD;
							end
						end else begin
							if (count_q < CW'(2)) begin
								res_status_q <= bsmmg_pkg::ST_FEW;
								state_q      <= S_FIN;
							end else begin
								res_status_q <= bsmmg_pkg::ST_OK;
								state_q      <= S_Q_RD;
							end
						end
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_CMP;
				end
				S_INS_CMP: begin
					// Shift the larger neighbour up, or drop the new value in place
					if (store_gt) begin
						pos_q   <= pos_dec;
						state_q <= (pos_dec == '0) ? S_INS_PUT : S_INS_RD;
					end else begin
						count_q <= count_q + 1'b1;
						state_q <= S_FIN;
					end
				end
				S_INS_PUT: begin
					count_q <= count_q + 1'b1;
					state_q <= S_FIN;
				end
				S_Q_RD: begin
					state_q <= S_Q_CMP;
				end
				S_Q_CMP: begin
					prev_q <= rd_data;
					if (idx_q == '0) begin
						first_q <= rd_data;
						idx_q   <= idx_inc;
						state_q <= S_Q_RD;
					end else begin
						gap_q   <= sub_diff[DW-1:0];
						state_q <= S_Q_MIN;
					end
				end
				S_Q_MIN: begin
					// Keep the smaller gap; the first gap seeds the minimum
					if (idx_q == CW'(1) || gap_less) begin
						short_q <= gap_q;
					end
					idx_q   <= idx_inc;
					state_q <= (idx_inc == count_q) ? S_Q_LONG : S_Q_RD;
				end
				S_Q_LONG: begin
					long_q  <= sub_diff[DW-1:0];
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_item_q.status       <= res_status_q;
						out_item_q.shortest_gap <= short_q;
						out_item_q.longest_gap  <= long_q;
						out_item_q.held_count   <= bsmmg_pkg::CAP_W'(count_q);
						state_q                 <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

/* hdl/bsmmg_check.sv */
// Port checker for the bounded set block, bound to the top level.
module bsmmg_check (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  bsmmg_pkg::in_item_t   in_item,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  bsmmg_pkg::out_item_t  out_item
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// Go busy after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block took an item without going busy");

	// Report zero gaps on any refused item
	a_err_gaps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != bsmmg_pkg::ST_OK |->
		out_item.shortest_gap == '0 && out_item.longest_gap == '0)
		else $error("gaps reported on a refused item");

	// Keep the shortest gap within the longest span
	a_gap_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.shortest_gap <= out_item.longest_gap)
		else $error("shortest gap exceeds longest span");

	// Refuse a query only when fewer than two numbers are held
	a_few: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == bsmmg_pkg::ST_FEW |-> out_item.held_count < 2)
		else $error("query refused with two or more numbers held");

endmodule

bind bounded_set_min_max_gap bsmmg_check u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
